[rtl/core/tse_pkg.sv]
// Shared types and constants for the translation shift estimator.
// No dependencies; every other file in rtl/core uses this package.
`timescale 1ns / 1ps

package tse_pkg;

    localparam int COORD_W  = 32;
    localparam int WEIGHT_W = 17;
    localparam int SUM_W    = 62;
    localparam int WSUM_W   = 29;
    localparam int DIV_W    = 64;
    localparam int DIVR_W   = 32;
    localparam int ROOT_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_EN = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PREP,
        S_DIV_TX,
        S_DIV_FX,
        S_DIV_TY,
        S_DIV_FY,
        S_DELTA,
        S_MUL_WX,
        S_MUL_WY,
        S_MUL_EX,
        S_MUL_EY,
        S_SQ_SUM,
        S_ROOT_GO,
        S_ROOT,
        S_FIT,
        S_DIV_GX,
        S_DIV_GY,
        S_OUT
    } tse_state_t;

    typedef enum logic [2:0] {
        OP_TX,
        OP_FX,
        OP_TY,
        OP_FY,
        OP_GX,
        OP_GY
    } tse_div_op_t;

    typedef enum logic [1:0] {
        MUL_WX,
        MUL_WY,
        MUL_EX,
        MUL_EY
    } tse_mul_op_t;

    typedef struct packed {
        logic        load;
        logic        div_start;
        tse_div_op_t div_op;
        logic        cap_en;
        tse_div_op_t cap_op;
        logic        delta_cap;
        logic        err_cap;
        logic        mul_en;
        tse_mul_op_t mul_op;
        logic        acc_x;
        logic        acc_y;
        logic        sq_cap;
        logic        sum_cap;
        logic        sqrt_start;
        logic        res_cap;
        logic        fit_cap;
        logic        out_load;
    } tse_cmd_t;

    typedef struct packed {
        logic bad;
        logic fit_go;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } tse_stat_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [DIV_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] abs32(input logic signed [COORD_W-1:0] v);
        logic [COORD_W-1:0] r;
        r = v[COORD_W-1] ? 32'(-v) : 32'(v);
        return r;
    endfunction

endpackage

[rtl/core/tse_pt_if.sv]
// Input channel: one homogeneous point correspondence per transfer.
// Depends on tse_pkg for field widths.
`timescale 1ns / 1ps

interface tse_pt_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tse_pkg::COORD_W-1:0]    from_x;
    logic signed [tse_pkg::COORD_W-1:0]    from_y;
    logic signed [tse_pkg::COORD_W-1:0]    from_scale;
    logic signed [tse_pkg::COORD_W-1:0]    to_x;
    logic signed [tse_pkg::COORD_W-1:0]    to_y;
    logic signed [tse_pkg::COORD_W-1:0]    to_scale;
    logic        [tse_pkg::WEIGHT_W-1:0]   weight;
    logic                                  last_point;

    modport source (
        output valid, from_x, from_y, from_scale, to_x, to_y, to_scale, weight, last_point,
        input  ready
    );
    modport sink (
        input  valid, from_x, from_y, from_scale, to_x, to_y, to_scale, weight, last_point,
        output ready
    );
endinterface

[rtl/core/tse_res_if.sv]
// Result channel: displacement, residual and fit per transfer.
// Depends on tse_pkg for field widths.
`timescale 1ns / 1ps

interface tse_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tse_pkg::COORD_W-1:0]    delta_x;
    logic signed [tse_pkg::COORD_W-1:0]    delta_y;
    logic        [tse_pkg::COORD_W-1:0]    residual;
    logic                                  bad_point;
    logic                                  fit_valid;
    logic signed [tse_pkg::COORD_W-1:0]    fit_x;
    logic signed [tse_pkg::COORD_W-1:0]    fit_y;
    logic                                  last_result;

    modport source (
        output valid, delta_x, delta_y, residual, bad_point, fit_valid, fit_x, fit_y,
        output last_result,
        input  ready
    );
    modport sink (
        input  valid, delta_x, delta_y, residual, bad_point, fit_valid, fit_x, fit_y,
        input  last_result,
        output ready
    );
endinterface

[rtl/core/translation_shift_estimator.sv]
// Top level of the translation shift estimator: controller plus datapath.
// Depends on tse_pkg, tse_pt_if, tse_res_if, tse_ctrl, tse_dp.
//
//   channel | direction | transfer content
//   pt      | in        | one point correspondence with weight and last mark
//   res     | out       | displacement, residual, bad flag, fit on last
//   cfg     | in        | register write: shift_x, shift_y, weighting_enabled
//
// One item at a time: a good item runs four divisions on the shared divider and
// a square root; a bad item skips both. A last item with a nonzero weight total
// adds two divisions.
// The result register holds one finished result while the next item runs.
// Reset clears the shifts, enables weighting and clears accumulators and control; no clearing pass.
`timescale 1ns / 1ps

module translation_shift_estimator #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    tse_pt_if.sink                               pt,
    tse_res_if.source                            res,
    input  logic                                 cfg_we,
    input  logic [tse_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tse_pkg::COORD_W-1:0]          cfg_data
);
    tse_pkg::tse_cmd_t  cmd;
    tse_pkg::tse_stat_t stat;
    logic               in_ready;

    assign pt.ready = in_ready;

    tse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pt.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tse_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt        (pt),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );
endmodule

[rtl/core/tse_div.sv]
// Iterative sign-magnitude divider, one quotient bit per cycle.
// Depends on tse_pkg.
`timescale 1ns / 1ps

module tse_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [tse_pkg::DIV_W-1:0]            dividend,
    input  logic [tse_pkg::DIVR_W-1:0]           divisor,
    input  logic                                 neg,
    output logic                                 done,
    output logic signed [tse_pkg::DIV_W-1:0]     quotient
);
    localparam int CNT_W = $clog2(tse_pkg::DIV_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [tse_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [tse_pkg::DIVR_W-1:0]    rem_reg, rem_next;
    logic [tse_pkg::DIVR_W-1:0]    dvs_reg, dvs_next;
    logic                          neg_reg, neg_next;
    logic [tse_pkg::DIVR_W:0]      shifted;
    logic [tse_pkg::DIVR_W:0]      diff;
    logic                          ge;

    assign shifted = {rem_reg, quo_reg[tse_pkg::DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = neg;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[tse_pkg::DIV_W-2:0], ge};
            rem_next = ge ? diff[tse_pkg::DIVR_W-1:0] : shifted[tse_pkg::DIVR_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(tse_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
endmodule

[rtl/core/tse_sqrt.sv]
// Iterative integer square root, one root bit per cycle, rounded down.
// Depends on tse_pkg.
`timescale 1ns / 1ps

module tse_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [2*tse_pkg::ROOT_W-1:0]     radicand,
    output logic                             done,
    output logic [tse_pkg::ROOT_W-1:0]       root
);
    localparam int RW    = tse_pkg::ROOT_W;
    localparam int CNT_W = $clog2(RW);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [2*RW-1:0]       v_reg, v_next;
    logic [RW-1:0]         r_reg, r_next;
    logic [RW:0]           rem_reg, rem_next;
    logic [RW+1:0]         rem2;
    logic [RW+1:0]         trial;
    logic [RW+1:0]         diff;
    logic                  ge;

    assign rem2  = {rem_reg[RW-1:0], v_reg[2*RW-1:2*RW-2]};
    assign trial = {r_reg, 2'b01};
    assign diff  = rem2 - trial;
    assign ge    = rem2 >= trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            v_next    = radicand;
            r_next    = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            v_next   = {v_reg[2*RW-3:0], 2'b00};
            r_next   = {r_reg[RW-2:0], ge};
            rem_next = ge ? diff[RW:0] : rem2[RW:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        r_reg   <= r_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign root = r_reg;
endmodule

[rtl/core/tse_dp.sv]
// Datapath: operand registers, shared multiplier, accumulators, config and
// output register. Depends on tse_pkg, tse_pt_if, tse_res_if, tse_div, tse_sqrt.
`timescale 1ns / 1ps

module tse_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    tse_pt_if.sink                               pt,
    tse_res_if.source                            res,
    input  logic                                 cfg_we,
    input  logic [tse_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tse_pkg::COORD_W-1:0]          cfg_data,
    input  tse_pkg::tse_cmd_t                    cmd,
    output tse_pkg::tse_stat_t                   stat
);
    localparam int CW = tse_pkg::COORD_W;
    localparam int SW = tse_pkg::SUM_W;
    localparam int WW = tse_pkg::WSUM_W;
    localparam int DW = tse_pkg::DIV_W;

    // config
    logic signed [CW-1:0]   shx_reg, shy_reg;
    logic                   wen_reg;

    // item operands
    logic signed [CW-1:0]   fx_reg, fy_reg, fs_reg, tx_reg, ty_reg, ts_reg;
    logic [tse_pkg::WEIGHT_W-1:0] w_reg;
    logic                   last_reg, bad_reg;

    // work registers
    logic signed [DW-1:0]   ntx_reg, nfx_reg, nty_reg, nfy_reg;
    logic signed [CW-1:0]   dx_reg, dy_reg;
    logic [CW:0]            ex_reg, ey_reg;
    logic                   big_reg;
    logic [DW-1:0]          prod_reg;
    logic                   pneg_reg;
    logic [DW-1:0]          sqx_reg;
    logic [DW-1:0]          rad_reg;
    logic                   rovf_reg;
    logic [CW-1:0]          res_reg;
    logic                   fitv_reg;
    logic signed [SW-1:0]   sumx_reg, sumx_next;
    logic signed [SW-1:0]   sumy_reg, sumy_next;
    logic [WW-1:0]          wsum_reg, wsum_next;

    // output register
    logic                   ov_reg, ov_next;
    logic signed [CW-1:0]   odx_reg, ody_reg, ofx_reg, ofy_reg;
    logic [CW-1:0]          ores_reg;
    logic                   obad_reg, ofv_reg, olast_reg;

    // divider operands
    logic signed [CW-1:0]   d_coord, d_scale;
    logic [DW-1:0]          d_dividend;
    logic [tse_pkg::DIVR_W-1:0] d_divisor;
    logic                   d_neg;
    logic                   div_done;
    logic signed [DW-1:0]   div_q;
    logic [SW-1:0]          sum_mag;

    logic [CW-1:0]          m_a, m_b;
    logic                   m_neg;
    logic [DW-1:0]          m_prod;

    logic signed [CW:0]     ex_s, ey_s;
    logic signed [SW:0]     term;
    logic signed [SW:0]     accx, accy;
    logic [WW:0]            wacc;
    logic [DW:0]            sqsum;
    logic                   sqrt_done;
    logic [tse_pkg::ROOT_W-1:0] root;
    logic [tse_pkg::WEIGHT_W-1:0] w_eff;

    always_comb
    begin
        d_coord = tx_reg;
        d_scale = ts_reg;
        unique case (cmd.div_op)
            tse_pkg::OP_TX: begin d_coord = tx_reg; d_scale = ts_reg; end
            tse_pkg::OP_FX: begin d_coord = fx_reg; d_scale = fs_reg; end
            tse_pkg::OP_TY: begin d_coord = ty_reg; d_scale = ts_reg; end
            tse_pkg::OP_FY: begin d_coord = fy_reg; d_scale = fs_reg; end
            default:        begin d_coord = tx_reg; d_scale = ts_reg; end
        endcase
    end

    always_comb
    begin
        sum_mag = '0;
        if (cmd.div_op == tse_pkg::OP_GX)
            sum_mag = sumx_reg[SW-1] ? SW'(-sumx_reg) : SW'(sumx_reg);
        else
            sum_mag = sumy_reg[SW-1] ? SW'(-sumy_reg) : SW'(sumy_reg);
        if (cmd.div_op == tse_pkg::OP_GX || cmd.div_op == tse_pkg::OP_GY)
        begin
            d_dividend = DW'(sum_mag);
            d_divisor  = tse_pkg::DIVR_W'(wsum_reg);
            d_neg      = (cmd.div_op == tse_pkg::OP_GX) ? sumx_reg[SW-1] : sumy_reg[SW-1];
        end
        else
        begin
            d_dividend = DW'(tse_pkg::abs32(d_coord)) << FRAC_BITS;
            d_divisor  = tse_pkg::abs32(d_scale);
            d_neg      = d_coord[CW-1] ^ d_scale[CW-1];
        end
    end

    tse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (d_dividend),
        .divisor  (d_divisor),
        .neg      (d_neg),
        .done     (div_done),
        .quotient (div_q)
    );

    tse_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (rad_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    // shared 32x32 multiplier
    always_comb
    begin
        m_a   = tse_pkg::abs32(dx_reg);
        m_b   = CW'(w_reg);
        m_neg = dx_reg[CW-1];
        unique case (cmd.mul_op)
            tse_pkg::MUL_WX: begin m_a = tse_pkg::abs32(dx_reg); m_b = CW'(w_reg);
                                   m_neg = dx_reg[CW-1]; end
            tse_pkg::MUL_WY: begin m_a = tse_pkg::abs32(dy_reg); m_b = CW'(w_reg);
                                   m_neg = dy_reg[CW-1]; end
            tse_pkg::MUL_EX: begin m_a = ex_reg[CW-1:0]; m_b = ex_reg[CW-1:0];
                                   m_neg = 1'b0; end
            tse_pkg::MUL_EY: begin m_a = ey_reg[CW-1:0]; m_b = ey_reg[CW-1:0];
                                   m_neg = 1'b0; end
            default:         begin m_a = '0; m_b = '0; m_neg = 1'b0; end
        endcase
    end
    assign m_prod = DW'(m_a) * DW'(m_b);

    assign ex_s  = {dx_reg[CW-1], dx_reg} - {shx_reg[CW-1], shx_reg};
    assign ey_s  = {dy_reg[CW-1], dy_reg} - {shy_reg[CW-1], shy_reg};
    assign term  = pneg_reg ? -$signed({15'd0, prod_reg[47:0]})
                            : $signed({15'd0, prod_reg[47:0]});
    assign accx  = {sumx_reg[SW-1], sumx_reg} + term;
    assign accy  = {sumy_reg[SW-1], sumy_reg} + term;
    assign wacc  = {1'b0, wsum_reg} + (WW+1)'(w_reg);
    assign sqsum = {1'b0, sqx_reg} + {1'b0, prod_reg};
    assign w_eff = (pt.weight > tse_pkg::WEIGHT_ONE || !wen_reg) ? tse_pkg::WEIGHT_ONE
                                                                : pt.weight;

    always_comb
    begin
        sumx_next = sumx_reg;
        sumy_next = sumy_reg;
        wsum_next = wsum_reg;
        if (cmd.acc_x)
            sumx_next = (accx[SW] != accx[SW-1])
                        ? {accx[SW], {(SW-1){~accx[SW]}}} : accx[SW-1:0];
        if (cmd.acc_y)
        begin
            sumy_next = (accy[SW] != accy[SW-1])
                        ? {accy[SW], {(SW-1){~accy[SW]}}} : accy[SW-1:0];
            wsum_next = wacc[WW] ? {WW{1'b1}} : wacc[WW-1:0];
        end
        if (cmd.out_load && last_reg)
        begin
            sumx_next = '0;
            sumy_next = '0;
            wsum_next = '0;
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (res.ready)
            ov_next = 1'b0;
        if (cmd.out_load)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shx_reg  <= '0;
            shy_reg  <= '0;
            wen_reg  <= 1'b1;
            sumx_reg <= '0;
            sumy_reg <= '0;
            wsum_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tse_pkg::CFG_SHIFT_X:   shx_reg <= cfg_data;
                    tse_pkg::CFG_SHIFT_Y:   shy_reg <= cfg_data;
                    tse_pkg::CFG_WEIGHT_EN: wen_reg <= cfg_data[0];
                    default:                ;
                endcase
            end
            sumx_reg <= sumx_next;
            sumy_reg <= sumy_next;
            wsum_reg <= wsum_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fx_reg   <= pt.from_x;
            fy_reg   <= pt.from_y;
            fs_reg   <= pt.from_scale;
            tx_reg   <= pt.to_x;
            ty_reg   <= pt.to_y;
            ts_reg   <= pt.to_scale;
            w_reg    <= w_eff;
            last_reg <= pt.last_point;
            bad_reg  <= (pt.from_scale == '0) || (pt.to_scale == '0);
            dx_reg   <= '0;
            dy_reg   <= '0;
            res_reg  <= '0;
        end
        if (cmd.cap_en)
        begin
            unique case (cmd.cap_op)
                tse_pkg::OP_TX: ntx_reg <= div_q;
                tse_pkg::OP_FX: nfx_reg <= div_q;
                tse_pkg::OP_TY: nty_reg <= div_q;
                tse_pkg::OP_FY: nfy_reg <= div_q;
                tse_pkg::OP_GX: ntx_reg <= div_q;
                tse_pkg::OP_GY: nty_reg <= div_q;
                default:        ;
            endcase
        end
        if (cmd.delta_cap)
        begin
            dx_reg <= tse_pkg::sat32(ntx_reg - nfx_reg);
            dy_reg <= tse_pkg::sat32(nty_reg - nfy_reg);
        end
        if (cmd.err_cap)
        begin
            ex_reg  <= ex_s[CW] ? (CW+1)'(-ex_s) : (CW+1)'(ex_s);
            ey_reg  <= ey_s[CW] ? (CW+1)'(-ey_s) : (CW+1)'(ey_s);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= m_prod;
            pneg_reg <= m_neg;
        end
        if (cmd.sq_cap)
        begin
            sqx_reg <= prod_reg;
            big_reg <= ex_reg[CW] || ey_reg[CW];
        end
        if (cmd.sum_cap)
        begin
            rad_reg  <= sqsum[DW-1:0];
            rovf_reg <= sqsum[DW];
        end
        if (cmd.res_cap)
            res_reg <= (big_reg || rovf_reg) ? {CW{1'b1}} : root;
        if (cmd.fit_cap)
            fitv_reg <= stat.fit_go;
        if (cmd.out_load)
        begin
            odx_reg   <= dx_reg;
            ody_reg   <= dy_reg;
            ores_reg  <= res_reg;
            obad_reg  <= bad_reg;
            ofv_reg   <= fitv_reg;
            ofx_reg   <= fitv_reg ? tse_pkg::sat32(ntx_reg) : '0;
            ofy_reg   <= fitv_reg ? tse_pkg::sat32(nty_reg) : '0;
            olast_reg <= last_reg;
        end
    end

    assign stat.bad       = bad_reg;
    assign stat.fit_go    = last_reg && (wsum_reg != '0);
    assign stat.div_done  = div_done;
    assign stat.sqrt_done = sqrt_done;
    assign stat.out_free  = !ov_reg || res.ready;

    assign res.valid       = ov_reg;
    assign res.delta_x     = odx_reg;
    assign res.delta_y     = ody_reg;
    assign res.residual    = ores_reg;
    assign res.bad_point   = obad_reg;
    assign res.fit_valid   = ofv_reg;
    assign res.fit_x       = ofx_reg;
    assign res.fit_y       = ofy_reg;
    assign res.last_result = olast_reg;
endmodule

[rtl/core/tse_ctrl.sv]
// Controller: sequences divisions, multiplies, root and output per item.
// Depends on tse_pkg.
`timescale 1ns / 1ps

module tse_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tse_pkg::tse_stat_t   stat,
    output tse_pkg::tse_cmd_t    cmd
);
    tse_pkg::tse_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tse_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            tse_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = tse_pkg::S_PREP;
                end
            end
            tse_pkg::S_PREP:
            begin
                if (stat.bad)
                    state_next = tse_pkg::S_FIT;
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = tse_pkg::OP_TX;
                    state_next    = tse_pkg::S_DIV_TX;
                end
            end
            tse_pkg::S_DIV_TX:
            if (stat.div_done)
            begin
                cmd.cap_en = 1'b1; cmd.cap_op = tse_pkg::OP_TX;
                cmd.div_start = 1'b1; cmd.div_op = tse_pkg::OP_FX;
                state_next = tse_pkg::S_DIV_FX;
            end
            tse_pkg::S_DIV_FX:
            if (stat.div_done)
            begin
                cmd.cap_en = 1'b1; cmd.cap_op = tse_pkg::OP_FX;
                cmd.div_start = 1'b1; cmd.div_op = tse_pkg::OP_TY;
                state_next = tse_pkg::S_DIV_TY;
            end
            tse_pkg::S_DIV_TY:
            if (stat.div_done)
            begin
                cmd.cap_en = 1'b1; cmd.cap_op = tse_pkg::OP_TY;
                cmd.div_start = 1'b1; cmd.div_op = tse_pkg::OP_FY;
                state_next = tse_pkg::S_DIV_FY;
            end
            tse_pkg::S_DIV_FY:
            if (stat.div_done)
            begin
                cmd.cap_en = 1'b1; cmd.cap_op = tse_pkg::OP_FY;
                state_next = tse_pkg::S_DELTA;
            end
            tse_pkg::S_DELTA:
            begin
                cmd.delta_cap = 1'b1;
                state_next    = tse_pkg::S_MUL_WX;
            end
            tse_pkg::S_MUL_WX:
            begin
                cmd.err_cap = 1'b1;
                cmd.mul_en  = 1'b1; cmd.mul_op = tse_pkg::MUL_WX;
                state_next  = tse_pkg::S_MUL_WY;
            end
            tse_pkg::S_MUL_WY:
            begin
                cmd.acc_x  = 1'b1;
                cmd.mul_en = 1'b1; cmd.mul_op = tse_pkg::MUL_WY;
                state_next = tse_pkg::S_MUL_EX;
            end
            tse_pkg::S_MUL_EX:
            begin
                cmd.acc_y  = 1'b1;
                cmd.mul_en = 1'b1; cmd.mul_op = tse_pkg::MUL_EX;
                state_next = tse_pkg::S_MUL_EY;
            end
            tse_pkg::S_MUL_EY:
            begin
                cmd.sq_cap = 1'b1;
                cmd.mul_en = 1'b1; cmd.mul_op = tse_pkg::MUL_EY;
                state_next = tse_pkg::S_SQ_SUM;
            end
            tse_pkg::S_SQ_SUM:
            begin
                cmd.sum_cap = 1'b1;
                state_next  = tse_pkg::S_ROOT_GO;
            end
            tse_pkg::S_ROOT_GO:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = tse_pkg::S_ROOT;
            end
            tse_pkg::S_ROOT:
            if (stat.sqrt_done)
            begin
                cmd.res_cap = 1'b1;
                state_next  = tse_pkg::S_FIT;
            end
            tse_pkg::S_FIT:
            begin
                cmd.fit_cap = 1'b1;
                if (stat.fit_go)
                begin
                    cmd.div_start = 1'b1; cmd.div_op = tse_pkg::OP_GX;
                    state_next = tse_pkg::S_DIV_GX;
                end
                else
                    state_next = tse_pkg::S_OUT;
            end
            tse_pkg::S_DIV_GX:
            begin
                cmd.div_op = tse_pkg::OP_GY;
                if (stat.div_done)
                begin
                    cmd.cap_en = 1'b1; cmd.cap_op = tse_pkg::OP_GX;
                    cmd.div_start = 1'b1;
                    state_next = tse_pkg::S_DIV_GY;
                end
            end
            tse_pkg::S_DIV_GY:
            if (stat.div_done)
            begin
                cmd.cap_en = 1'b1; cmd.cap_op = tse_pkg::OP_GY;
                state_next = tse_pkg::S_OUT;
            end
            tse_pkg::S_OUT:
            if (stat.out_free)
            begin
                cmd.out_load = 1'b1;
                state_next   = tse_pkg::S_IDLE;
            end
            default:
                state_next = tse_pkg::S_IDLE;
        endcase
    end
endmodule

[test/tb_translation_shift_estimator.sv]
// Testbench for translation_shift_estimator: random and directed point transfers,
// with a scoreboard that predicts displacement, residual and the weighted mean fit.
// Depends on tse_pkg, tse_pt_if, tse_res_if and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_translation_shift_estimator;

    localparam longint CYCLE_LIMIT = 4000000;
    localparam longint SUM_TOP = (64'sd1 <<< 61) - 1;
    localparam longint SUM_BOT = -SUM_TOP - 1;
    localparam longint WSUM_TOP = (64'sd1 <<< 29) - 1;
    localparam longint UNIT_WEIGHT = 65536;

    typedef struct {
        logic signed [tse_pkg::COORD_W-1:0] fx, fy, fs, tx, ty, ts;
        logic [tse_pkg::WEIGHT_W-1:0]       weight;
        logic                               last;
    } point_t;

    typedef struct {
        logic signed [tse_pkg::COORD_W-1:0] dx, dy;
        logic [tse_pkg::COORD_W-1:0]        residual;
        logic                               bad;
        logic                               fit_ok;
        logic signed [tse_pkg::COORD_W-1:0] fit_x, fit_y;
        logic                               last;
    } shift_result_t;

    class shift_scoreboard;
        longint        shift_x, shift_y;
        bit            use_weights;
        longint        dx_sum, dy_sum, weight_total;
        shift_result_t pending_results[$];
        int            errors;

        function new();
            shift_x = 0;
            shift_y = 0;
            use_weights = 1;
            dx_sum = 0;
            dy_sum = 0;
            weight_total = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [tse_pkg::CFG_IDX_W-1:0] idx,
                                logic [tse_pkg::COORD_W-1:0] data);
            if (idx == tse_pkg::CFG_SHIFT_X)
                shift_x = longint'($signed(data));
            else if (idx == tse_pkg::CFG_SHIFT_Y)
                shift_y = longint'($signed(data));
            else if (idx == tse_pkg::CFG_WEIGHT_EN)
                use_weights = data[0];
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint clamp_sum(longint v);
            if (v > SUM_TOP)
                return SUM_TOP;
            if (v < SUM_BOT)
                return SUM_BOT;
            return v;
        endfunction

        function longint project(longint c, longint s);
            return (c * 65536) / s;
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function logic [tse_pkg::COORD_W-1:0] span(longint ex, longint ey);
            longint unsigned ax, ay;
            logic [64:0]     total;
            ax = ex < 0 ? longint'(-ex) : ex;
            ay = ey < 0 ? longint'(-ey) : ey;
            if (ax > 64'hFFFFFFFF || ay > 64'hFFFFFFFF)
                return 32'hFFFFFFFF;
            total = {1'b0, ax * ax} + {1'b0, ay * ay};
            if (total[64])
                return 32'hFFFFFFFF;
            return 32'(int_root(total[63:0]));
        endfunction

        function void note_point(point_t p);
            shift_result_t e;
            longint        w, dx, dy;
            w = p.weight;
            if (w > UNIT_WEIGHT || !use_weights)
                w = UNIT_WEIGHT;
            e.bad = (p.fs == 0) || (p.ts == 0);
            e.dx = 0;
            e.dy = 0;
            e.residual = 0;
            e.fit_ok = 0;
            e.fit_x = 0;
            e.fit_y = 0;
            e.last = p.last;
            if (!e.bad)
            begin
                dx = clamp32(project(p.tx, p.ts) - project(p.fx, p.fs));
                dy = clamp32(project(p.ty, p.ts) - project(p.fy, p.fs));
                e.dx = 32'(dx);
                e.dy = 32'(dy);
                e.residual = span(dx - shift_x, dy - shift_y);
                dx_sum = clamp_sum(dx_sum + dx * w);
                dy_sum = clamp_sum(dy_sum + dy * w);
                weight_total = weight_total + w;
                if (weight_total > WSUM_TOP)
                    weight_total = WSUM_TOP;
            end
            if (p.last)
            begin
                if (weight_total != 0)
                begin
                    e.fit_ok = 1;
                    e.fit_x = 32'(clamp32(dx_sum / weight_total));
                    e.fit_y = 32'(clamp32(dy_sum / weight_total));
                end
                dx_sum = 0;
                dy_sum = 0;
                weight_total = 0;
            end
            pending_results.insert(pending_results.size(), e);
        endfunction

        function void check_result(shift_result_t got);
            shift_result_t e;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer: dx=%0d dy=%0d", got.dx, got.dy);
                return;
            end
            e = pending_results.pop_front();
            if (got.dx !== e.dx || got.dy !== e.dy || got.residual !== e.residual
                || got.bad !== e.bad || got.fit_ok !== e.fit_ok || got.fit_x !== e.fit_x
                || got.fit_y !== e.fit_y || got.last !== e.last)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch exp: dx=%0d dy=%0d res=%0d bad=%0b fv=%0b",
                             e.dx, e.dy, e.residual, e.bad, e.fit_ok);
                    $display("              fx=%0d fy=%0d l=%0b", e.fit_x, e.fit_y, e.last);
                    $display("         got: dx=%0d dy=%0d res=%0d bad=%0b fv=%0b",
                             got.dx, got.dy, got.residual, got.bad, got.fit_ok);
                    $display("              fx=%0d fy=%0d l=%0b", got.fit_x, got.fit_y,
                             got.last);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [tse_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tse_pkg::COORD_W-1:0]   cfg_data;
    int   src_idle;
    int   snk_idle;
    longint cycles;
    int   set_left;
    shift_scoreboard book;

    tse_pt_if  pt_bus();
    tse_res_if res_bus();

    translation_shift_estimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt        (pt_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
        res_bus.ready <= rst_n && ($urandom_range(99) >= snk_idle);

    always @(posedge clk)
    begin
        shift_result_t got;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got.dx = res_bus.delta_x;
            got.dy = res_bus.delta_y;
            got.residual = res_bus.residual;
            got.bad = res_bus.bad_point;
            got.fit_ok = res_bus.fit_valid;
            got.fit_x = res_bus.fit_x;
            got.fit_y = res_bus.fit_y;
            got.last = res_bus.last_result;
            book.check_result(got);
        end
    end

    task automatic write_reg(logic [tse_pkg::CFG_IDX_W-1:0] idx,
                             logic [tse_pkg::COORD_W-1:0] data);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        book.write_reg(idx, data);
    endtask

    task automatic wait_drained();
        pt_bus.valid <= 0;
        while (book.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_point(point_t p);
        if ($urandom_range(99) < src_idle)
        begin
            pt_bus.valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pt_bus.valid <= 1;
        pt_bus.from_x <= p.fx;
        pt_bus.from_y <= p.fy;
        pt_bus.from_scale <= p.fs;
        pt_bus.to_x <= p.tx;
        pt_bus.to_y <= p.ty;
        pt_bus.to_scale <= p.ts;
        pt_bus.weight <= p.weight;
        pt_bus.last_point <= p.last;
        do
            @(posedge clk);
        while (!pt_bus.ready);
        book.note_point(p);
    endtask

    task automatic send_fixed(int fx, int fy, int fs, int tx, int ty, int ts, int w, bit l);
        point_t p;
        p.fx = fx;
        p.fy = fy;
        p.fs = fs;
        p.tx = tx;
        p.ty = ty;
        p.ts = ts;
        p.weight = tse_pkg::WEIGHT_W'(w);
        p.last = l;
        send_point(p);
    endtask

    function automatic logic signed [tse_pkg::COORD_W-1:0] rand_coord();
        if ($urandom_range(3) == 0)
            return $urandom;
        return $signed($urandom) >>> $urandom_range(8, 31);
    endfunction

    function automatic logic signed [tse_pkg::COORD_W-1:0] rand_scale();
        int r;
        logic signed [tse_pkg::COORD_W-1:0] s;
        r = $urandom_range(99);
        if (r < 5)
            return 0;
        if (r < 15)
            return $urandom;
        s = $urandom_range(1, 4) << $urandom_range(12, 18);
        return $urandom_range(1) ? -s : s;
    endfunction

    task automatic send_random();
        point_t p;
        if (set_left == 0)
            set_left = $urandom_range(1, 8);
        set_left--;
        p.fx = rand_coord();
        p.fy = rand_coord();
        p.fs = rand_scale();
        p.tx = rand_coord();
        p.ty = rand_coord();
        p.ts = rand_scale();
        case ($urandom_range(9))
            0: p.weight = tse_pkg::WEIGHT_W'($urandom_range(131071));
            1: p.weight = 0;
            default: p.weight = tse_pkg::WEIGHT_W'($urandom_range(65536));
        endcase
        p.last = (set_left == 0);
        send_point(p);
    endtask

    initial
    begin
        book = new();
        cycles = 0;
        set_left = 0;
        src_idle = 13;
        snk_idle = 59;
        rst_n <= 0;
        cfg_we <= 0;
        cfg_index <= tse_pkg::CFG_SHIFT_X;
        cfg_data <= 0;
        pt_bus.valid <= 0;
        pt_bus.from_x <= 0;
        pt_bus.from_y <= 0;
        pt_bus.from_scale <= 0;
        pt_bus.to_x <= 0;
        pt_bus.to_y <= 0;
        pt_bus.to_scale <= 0;
        pt_bus.weight <= 0;
        pt_bus.last_point <= 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, bad scales, weight corners, zero-weight sets
        send_fixed(0, 0, 65536, 65536, -65536, 65536, 65536, 1);
        send_fixed(32'h80000000, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 32'h80000000, 1, 65536, 0);
        send_fixed(32'h7FFFFFFF, 32'h80000000, -1, 32'h80000000, 32'h7FFFFFFF, -1, 131071, 1);
        send_fixed(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 1, 1);
        send_fixed(100, 200, 0, 300, 400, 65536, 65536, 0);
        send_fixed(100, 200, 65536, 300, 400, 0, 65536, 0);
        send_fixed(100, 200, 0, 300, 400, 0, 65536, 1);
        send_fixed(65536, 65536, 65536, 131072, 0, 65536, 0, 0);
        send_fixed(-65536, 3, 65536, 7, 5, 65536, 0, 1);
        send_fixed(5, 6, 65536, 9, 9, 131072, 65535, 0);
        send_fixed(-7, 1, -65536, 3, 4, 32768, 65537, 0);
        send_fixed(1, 1, 65536, 2, 2, 65536, 32768, 0);
        send_fixed(9, 9, 0, 9, 9, 9, 65536, 1);
        send_fixed(123456, -654321, 3, -99999, 88888, -7, 77, 1);
        send_fixed(32'hFFFFFFFF, 0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 131071, 1);

        for (int seg = 0; seg < 6; seg++)
        begin
            wait_drained();
            src_idle = seg < 2 ? 13 : (seg < 4 ? 59 : 0);
            snk_idle = seg < 2 ? 59 : (seg < 4 ? 13 : 0);
            case (seg)
                0:
                begin
                    write_reg(tse_pkg::CFG_SHIFT_X, 0);
                    write_reg(tse_pkg::CFG_SHIFT_Y, 0);
                    write_reg(tse_pkg::CFG_WEIGHT_EN, 1);
                end
                1:
                begin
                    write_reg(tse_pkg::CFG_SHIFT_X, 32'h7FFFFFFF);
                    write_reg(tse_pkg::CFG_SHIFT_Y, 32'h80000000);
                    write_reg(tse_pkg::CFG_WEIGHT_EN, 0);
                end
                2:
                begin
                    write_reg(tse_pkg::CFG_SHIFT_X, 32'h80000000);
                    write_reg(tse_pkg::CFG_SHIFT_Y, 32'h7FFFFFFF);
                    write_reg(tse_pkg::CFG_WEIGHT_EN, 1);
                end
                default:
                begin
                    write_reg(tse_pkg::CFG_SHIFT_X, $signed($urandom) >>> $urandom_range(0, 20));
                    write_reg(tse_pkg::CFG_SHIFT_Y, $signed($urandom) >>> $urandom_range(0, 20));
                    write_reg(tse_pkg::CFG_WEIGHT_EN, $urandom_range(1));
                end
            endcase
            cfg_we <= 0;
            set_left = 0;
            for (int k = 0; k < 305; k++)
                send_random();
            if (set_left != 0)
                send_fixed(0, 0, 65536, 0, 0, 65536, 65536, 1);
        end

        wait_drained();
        if (book.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[translation_shift_estimator.f]
rtl/core/tse_pkg.sv
rtl/core/tse_pt_if.sv
rtl/core/tse_res_if.sv
rtl/core/tse_div.sv
rtl/core/tse_sqrt.sv
rtl/core/tse_dp.sv
rtl/core/tse_ctrl.sv
rtl/core/translation_shift_estimator.sv
test/tb_translation_shift_estimator.sv
